// ===== rtl/odwd_pkg.sv =====
// ----------------------------------------------------------------------------
// odwd_pkg
// Shared constants for the ordered deque with delete: action and status
// codes and the default store depth.
// ----------------------------------------------------------------------------
package odwd_pkg;

  // Default number of stored values.
  localparam int DEPTH_DEFAULT = 16;

  // Action codes carried by an input beat.
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [1:0] ACT_REMOVE     = 2'd2;
  localparam logic [1:0] ACT_READ       = 2'd3;

  // Status codes carried by a result beat.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

endpackage

// ===== rtl/ordered_deque_with_delete.sv =====
// ----------------------------------------------------------------------------
// ordered_deque_with_delete
// Ordered sequence of up to DEPTH signed 32-bit values kept in a circular
// buffer. Supports push front, push back, remove first match and read-out.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ------------------------
//  input     start / busy       action, value
//  result    valid (one cycle)  element, status, last
//
// Pushes, a remove from an empty store and a read-out of an empty store
// are answered without leaving the idle state, so busy stays low. A remove
// walks the store through one memory read port and one comparator: it
// searches from the front for the first entry equal to the value, then
// moves each entry behind it one place toward the front to close the gap.
// A read-out streams one element per cycle from front to back.
// Reset (rst, synchronous) empties the store; the memory is not cleared.
// The receiver cannot stall: each result beat is valid for one cycle only.
//
module ordered_deque_with_delete
  import odwd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               valid,
  output logic signed [31:0] element,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]         state;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pidx;
  logic               pend;
  logic [AW-1:0]      last_addr;
  logic [AW-1:0]      dst;
  logic signed [31:0] key;

  logic signed [31:0] mem [0:DEPTH-1];
  logic signed [31:0] rd_data;

  logic [CW-1:0]      lidx;
  logic [CW:0]        sum;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      head_dec;
  logic               full;
  logic               issue;
  logic               match;
  logic               at_end;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  assign busy = (state != S_IDLE);

  // Logical to physical index: one narrow add and a wrap compare.
  assign lidx = (state == S_IDLE) ? count : idx;
  always_comb begin
    sum = (CW+1)'(head) + {1'b0, lidx};
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
  end
  assign rd_addr = sum[AW-1:0];

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign full     = (count == CW'(DEPTH));
  assign issue    = (idx < count);
  assign match    = pend && (rd_data == key);
  assign at_end   = (CW'(pidx + 1'b1) == count);

  // Memory write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = value;
    case (state)
      S_IDLE: begin
        if (start && !full) begin
          if (action == ACT_PUSH_FRONT) begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
          end else if (action == ACT_PUSH_BACK) begin
            wr_en   = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        wr_en   = pend;
        wr_addr = dst;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Store memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      idx   <= '0;
      pidx  <= '0;
      pend  <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            element <= '0;
            last    <= 1'b1;
            idx     <= '0;
            pend    <= 1'b0;
            key     <= value;
            case (action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                valid <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= count + 1'b1;
                  if (action == ACT_PUSH_FRONT) begin
                    head <= head_dec;
                  end
                end
              end
              ACT_REMOVE: begin
                if (count == '0) begin
                  valid  <= 1'b1;
                  status <= ST_NOT_FOUND;
                end else begin
                  state <= S_SEARCH;
                end
              end
              default: begin
                if (count == '0) begin
                  valid  <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end

        // Walk from the front, comparing each returned entry with the key.
        S_SEARCH: begin
          if (match) begin
            state <= S_SHIFT;
            dst   <= last_addr;
            idx   <= CW'(pidx + 1'b1);
            pend  <= 1'b0;
          end else if (pend && at_end) begin
            state   <= S_IDLE;
            pend    <= 1'b0;
            valid   <= 1'b1;
            element <= '0;
            status  <= ST_NOT_FOUND;
            last    <= 1'b1;
          end else if (issue) begin
            pend      <= 1'b1;
            pidx      <= idx;
            idx       <= idx + 1'b1;
            last_addr <= rd_addr;
          end
        end

        // Move each entry behind the gap one place toward the front.
        S_SHIFT: begin
          if (pend) begin
            dst <= last_addr;
          end
          if (issue) begin
            pend      <= 1'b1;
            pidx      <= idx;
            idx       <= idx + 1'b1;
            last_addr <= rd_addr;
          end else begin
            state   <= S_IDLE;
            pend    <= 1'b0;
            count   <= count - 1'b1;
            valid   <= 1'b1;
            element <= '0;
            status  <= ST_OK;
            last    <= 1'b1;
          end
        end

        // Stream entries front to back, one beat per cycle.
        default: begin
          if (pend) begin
            valid   <= 1'b1;
            element <= rd_data;
            status  <= ST_OK;
            last    <= at_end;
          end
          if (pend && at_end) begin
            state <= S_IDLE;
            pend  <= 1'b0;
          end else if (issue) begin
            pend <= 1'b1;
            pidx <= idx;
            idx  <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule
